[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define SEBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sebd: assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define SEBD_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("sebd: assertion failed");

`endif

[rtl/sebd_pkg.sv]
// Package: constants, types and register codes of the sound energy beat detector.
`timescale 1ns / 1ps
`default_nettype none

package sebd_pkg;

    // History store size and the widths that follow from it
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int ENERGY_W   = 23;
    localparam int SPS_W      = 8;
    localparam int HSETS_W    = 7;
    localparam int BLF_W      = 16;
    localparam int VF_W       = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // Arithmetic widths
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_W     = 2 * ENERGY_W;
    localparam int VHI_W    = SQ_W - MUL_W;
    localparam int TOTAL_W  = ENERGY_W + HIST_CW;
    localparam int VACC_W   = SQ_W + HIST_CW;
    localparam int DIV_W    = VACC_W;
    localparam int DIV_CW   = $clog2(DIV_W + 1);
    localparam int HSUM_W   = VHI_W + VF_W + 1;
    localparam int TSC_W    = MUL_W - 4;
    localparam int LHS_W    = ENERGY_W + 12;
    localparam int RHS_W    = BLF_W + ENERGY_W;
    localparam int CMP_W    = (HSETS_W > HIST_CW) ? HSETS_W : HIST_CW;

    // Register reset values
    localparam logic [SPS_W-1:0]   SPS_RESET   = 8'd64;
    localparam logic [HSETS_W-1:0] HSETS_RESET = 7'd43;
    localparam logic [BLF_W-1:0]   BLF_RESET   = 16'd6202;
    localparam logic [VF_W-1:0]    VF_RESET    = 32'd0;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLES_PER_SET   = 2'd0,
        REG_HISTORY_SETS      = 2'd1,
        REG_BEAT_LEVEL_FACTOR = 2'd2,
        REG_VARIANCE_FACTOR   = 2'd3
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_SUM,
        ST_MEAN_DIV,
        ST_VAR,
        ST_VAR_DIV,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_THRESH,
        ST_RATIO,
        ST_BEAT,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/sebd_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sebd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/sound_energy_beat_detector_top.sv]
// Top level: sound energy beat detector with a shared multiplier and a radix-2 divider.
// A sample that does not close a set is squared and accumulated while the input is
//   closed; a closing sample then runs memory passes over the history (sum, variance,
//   shift) and two bit-serial divisions by n (n = used history length).
// The input takes no new sample until the last one is through; s_ready is low while busy.
// Reset: synchronous, active low; a clearing pass zeroes all HISTORY_DEPTH (64) entries
//   of the history memory, with s_ready low; configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module sound_energy_beat_detector_top
    import sebd_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // sample input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [SAMPLE_W-1:0]   s_sample,
    // result output
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_beat_found,
    output logic             [ENERGY_W-1:0]   m_mean_energy,
    output logic             [ENERGY_W-1:0]   m_set_energy,
    // configuration writes
    input  wire logic                         cfg_wr_en,
    input  wire logic        [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic        [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SPS_W-1:0]   sps_reg;
    logic [HSETS_W-1:0] hsets_reg;
    logic [BLF_W-1:0]   blf_reg;
    logic [VF_W-1:0]    vf_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [HIST_CW-1:0]         idx_reg;       // memory pass counter
    logic                       rd_vld_reg;    // history read data valid
    logic                       prod_vld_reg;  // squared deviation valid
    logic [HIST_AW-1:0]         wr_idx_reg;    // shift pass write address
    logic [DIV_CW-1:0]          div_cnt_reg;
    logic [ENERGY_W-1:0]        energy_reg;
    logic [SPS_W-1:0]           count_reg;
    logic                       m_valid_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [VACC_W-1:0]          vacc_reg;
    logic [HIST_CW-1:0]         div_rem_reg;
    logic [DIV_W-1:0]           div_quo_reg;
    logic [ENERGY_W-1:0]        mean_reg;
    logic [SQ_W-1:0]            var_reg;
    logic [MUL_W-1:0]           plo_hi_reg;
    logic [BLF_W-1:0]           c_reg;
    logic                       c_neg_reg;
    logic                       beat_reg;
    logic                       m_beat_reg;
    logic [ENERGY_W-1:0]        m_mean_reg;
    logic [ENERGY_W-1:0]        m_energy_reg;

    // ------------------------------------------------------------------
    // Used history length: zero counts as one, clamp at the store depth
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]   hsets_ext;
    logic [HIST_CW-1:0] n_used;
    logic [HIST_CW-1:0] idx_dec;

    assign hsets_ext = CMP_W'(hsets_reg);

    always_comb begin
        priority if (hsets_ext == '0) begin
            n_used = HIST_CW'(1);
        end else if (hsets_ext > CMP_W'(HISTORY_DEPTH)) begin
            n_used = HIST_CW'(HISTORY_DEPTH);
        end else begin
            n_used = hsets_ext[HIST_CW-1:0];
        end
    end

    assign idx_dec = idx_reg - HIST_CW'(1);

    // ------------------------------------------------------------------
    // History memory
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr;
    logic [ENERGY_W-1:0] ram_wdata;
    logic [HIST_AW-1:0]  ram_raddr;
    logic [ENERGY_W-1:0] ram_rdata;

    sebd_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared operands
    // ------------------------------------------------------------------
    logic [SAMPLE_W:0]   s_ext;
    logic [SAMPLE_W:0]   s_abs_full;
    logic [SAMPLE_W-1:0] s_abs;
    logic [ENERGY_W:0]   dev_full;
    logic [ENERGY_W:0]   dev_abs_full;
    logic [ENERGY_W-1:0] dev_abs;

    // |sample|: the most negative code maps to 2^15, which still fits 16 bits
    assign s_ext      = {sample_reg[SAMPLE_W-1], sample_reg};
    assign s_abs_full = s_ext[SAMPLE_W] ? (~s_ext + (SAMPLE_W+1)'(1)) : s_ext;
    assign s_abs      = s_abs_full[SAMPLE_W-1:0];

    // |history entry - mean|, squared by the shared multiplier
    assign dev_full     = {1'b0, ram_rdata} - {1'b0, mean_reg};
    assign dev_abs_full = dev_full[ENERGY_W] ? (~dev_full + (ENERGY_W+1)'(1)) : dev_full;
    assign dev_abs      = dev_abs_full[ENERGY_W-1:0];

    // ------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------
    logic             issue;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;

    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = idx_reg[HIST_AW-1:0];
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                // zero one history entry per cycle
                ram_we    = 1'b1;
                ram_waddr = idx_reg[HIST_AW-1:0];
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SQUARE: begin
                mul_a = MUL_W'(s_abs);
                mul_b = MUL_W'(s_abs);
            end
            ST_SUM: begin
                issue = (idx_reg < n_used);
            end
            ST_VAR: begin
                issue = (idx_reg < n_used);
                mul_a = MUL_W'(dev_abs);
                mul_b = MUL_W'(dev_abs);
            end
            ST_SCALE_LO: begin
                mul_a = var_reg[MUL_W-1:0];
                mul_b = vf_reg;
            end
            ST_SCALE_HI: begin
                mul_a = MUL_W'(var_reg[SQ_W-1:MUL_W]);
                mul_b = vf_reg;
            end
            ST_RATIO: begin
                mul_a = MUL_W'(c_reg);
                mul_b = MUL_W'(mean_reg);
            end
            ST_SHIFT: begin
                // read entry i-1, write it to entry i, walking down; the new
                // energy lands in entry 0 once the copies have drained
                issue     = (idx_reg != '0);
                ram_raddr = idx_dec[HIST_AW-1:0];
                if (rd_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx_reg;
                    ram_wdata = ram_rdata;
                end else if (!issue) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = energy_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic [SPS_W-1:0] count_inc;
    logic             div_done;

    assign count_inc = count_reg + SPS_W'(1);
    assign div_done  = (div_cnt_reg == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (idx_reg == HIST_CW'(HISTORY_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_SQUARE;
            end
            ST_SQUARE:   state_next = ST_ACCUM;
            ST_ACCUM: begin
                state_next = (count_inc == sps_reg) ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                if (!issue && !rd_vld_reg) state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                if (div_done) state_next = ST_VAR;
            end
            ST_VAR: begin
                if (!issue && !rd_vld_reg && !prod_vld_reg) state_next = ST_VAR_DIV;
            end
            ST_VAR_DIV: begin
                if (div_done) state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO: state_next = ST_SCALE_HI;
            ST_SCALE_HI: state_next = ST_THRESH;
            ST_THRESH:   state_next = ST_RATIO;
            ST_RATIO:    state_next = ST_BEAT;
            ST_BEAT:     state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (!issue && !rd_vld_reg) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Energy accumulate with saturation
    // ------------------------------------------------------------------
    logic [ENERGY_W:0] energy_add;

    assign energy_add = {1'b0, energy_reg} + (ENERGY_W+1)'(prod_reg[2*SAMPLE_W-2:SAMPLE_W-1]);

    // ------------------------------------------------------------------
    // Divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [HIST_CW:0]   div_trial;
    logic               div_fit;
    logic [HIST_CW:0]   div_diff;

    assign div_trial = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_fit   = (div_trial >= (HIST_CW+1)'(n_used));
    assign div_diff  = div_trial - (HIST_CW+1)'(n_used);

    // ------------------------------------------------------------------
    // Threshold: t = (var * variance_factor) >> 36, saturating at 2^32
    // ------------------------------------------------------------------
    logic [HSUM_W-1:0] hi_sum;
    logic              t_sat;
    logic [TSC_W-1:0]  t_val;

    assign hi_sum = HSUM_W'(prod_reg[VHI_W+VF_W-1:0]) + HSUM_W'(plo_hi_reg);
    assign t_sat  = |hi_sum[HSUM_W-1:MUL_W];
    assign t_val  = hi_sum[MUL_W-1:4];

    logic [RHS_W-1:0] lhs_val;

    assign lhs_val = RHS_W'({energy_reg, 12'd0});

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            div_cnt_reg  <= '0;
            energy_reg   <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            sps_reg      <= SPS_RESET;
            hsets_reg    <= HSETS_RESET;
            blf_reg      <= BLF_RESET;
            vf_reg       <= VF_RESET;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= (state_reg == ST_VAR) && rd_vld_reg;

            // register writes; every index maps to a register
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_SAMPLES_PER_SET:   sps_reg   <= cfg_wdata[SPS_W-1:0];
                    REG_HISTORY_SETS:      hsets_reg <= cfg_wdata[HSETS_W-1:0];
                    REG_BEAT_LEVEL_FACTOR: blf_reg   <= cfg_wdata[BLF_W-1:0];
                    REG_VARIANCE_FACTOR:   vf_reg    <= cfg_wdata[VF_W-1:0];
                    default: begin
                    end
                endcase
            end

            // offer a new result; drop the old one once the sink takes it
            if ((state_reg == ST_DONE) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    idx_reg <= idx_reg + HIST_CW'(1);
                end
                ST_ACCUM: begin
                    energy_reg <= energy_add[ENERGY_W] ? ENERGY_MAX : energy_add[ENERGY_W-1:0];
                    count_reg  <= count_inc;
                    idx_reg    <= '0;
                end
                ST_SUM: begin
                    if (issue) idx_reg <= idx_reg + HIST_CW'(1);
                    if (!issue && !rd_vld_reg) div_cnt_reg <= DIV_CW'(TOTAL_W);
                end
                ST_MEAN_DIV: begin
                    if (!div_done) div_cnt_reg <= div_cnt_reg - DIV_CW'(1);
                    else idx_reg <= '0;
                end
                ST_VAR: begin
                    if (issue) idx_reg <= idx_reg + HIST_CW'(1);
                    if (!issue && !rd_vld_reg && !prod_vld_reg) div_cnt_reg <= DIV_CW'(DIV_W);
                end
                ST_VAR_DIV: begin
                    if (!div_done) div_cnt_reg <= div_cnt_reg - DIV_CW'(1);
                end
                ST_BEAT: begin
                    idx_reg <= n_used - HIST_CW'(1);
                end
                ST_SHIFT: begin
                    if (issue) idx_reg <= idx_dec;
                end
                ST_DONE: begin
                    // hand over the result, then start a fresh set
                    if (!m_valid_reg || m_ready) begin
                        energy_reg  <= '0;
                        count_reg   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) sample_reg <= s_sample;
            end
            ST_ACCUM: begin
                total_reg <= '0;
            end
            ST_SUM: begin
                if (rd_vld_reg) total_reg <= total_reg + TOTAL_W'(ram_rdata);
                if (!issue && !rd_vld_reg) begin
                    div_quo_reg <= {total_reg, {(DIV_W - TOTAL_W){1'b0}}};
                    div_rem_reg <= '0;
                end
            end
            ST_MEAN_DIV, ST_VAR_DIV: begin
                if (!div_done) begin
                    div_rem_reg <= div_fit ? div_diff[HIST_CW-1:0] : div_trial[HIST_CW-1:0];
                    div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_fit};
                end else if (state_reg == ST_MEAN_DIV) begin
                    mean_reg <= div_quo_reg[ENERGY_W-1:0];
                    vacc_reg <= '0;
                end else begin
                    var_reg <= div_quo_reg[SQ_W-1:0];
                end
            end
            ST_VAR: begin
                if (prod_vld_reg) vacc_reg <= vacc_reg + VACC_W'(prod_reg[SQ_W-1:0]);
                if (!issue && !rd_vld_reg && !prod_vld_reg) begin
                    div_quo_reg <= vacc_reg;
                    div_rem_reg <= '0;
                end
            end
            ST_SCALE_HI: begin
                plo_hi_reg <= prod_reg[PROD_W-1:MUL_W];
            end
            ST_THRESH: begin
                c_neg_reg <= t_sat || (t_val > TSC_W'(blf_reg));
                c_reg     <= blf_reg - t_val[BLF_W-1:0];
            end
            ST_BEAT: begin
                // a negative ratio gives a threshold at or below zero
                if (c_neg_reg) begin
                    beat_reg <= (mean_reg != '0) || (energy_reg != '0);
                end else begin
                    beat_reg <= lhs_val > prod_reg[RHS_W-1:0];
                end
            end
            ST_SHIFT: begin
                if (issue) wr_idx_reg <= idx_reg[HIST_AW-1:0];
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_beat_reg   <= beat_reg;
                    m_mean_reg   <= mean_reg;
                    m_energy_reg <= energy_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_beat_found  = m_beat_reg;
    assign m_mean_energy = m_mean_reg;
    assign m_set_energy  = m_energy_reg;

endmodule

`default_nettype wire

[rtl/sebd_checker.sv]
// Checker: port-level assertions on the beat detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sebd_checker
    import sebd_pkg::*;
(
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_beat_found,
    input wire logic        [ENERGY_W-1:0]   m_mean_energy,
    input wire logic        [ENERGY_W-1:0]   m_set_energy
);

    logic [2*ENERGY_W:0] m_payload;

    assign m_payload = {m_beat_found, m_mean_energy, m_set_energy};

    // a stalled result stays offered
    `SEBD_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)

    // a stalled result keeps its payload
    `SEBD_ASSERT_NEXT(a_result_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_payload))

    // each sample transfer closes the input in the cycle after it
    `SEBD_ASSERT_NEXT(a_busy_after_sample, aclk, aresetn, s_valid && s_ready, !s_ready)

    // right after reset the history clear is running and no result is offered
    `SEBD_ASSERT(a_reset_quiet, aclk, aresetn, !$past(aresetn) |-> (!s_ready && !m_valid))

    // a new result only follows a busy cycle
    `SEBD_ASSERT(a_result_after_work, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready))

endmodule

bind sound_energy_beat_detector_top sebd_checker u_sebd_checker (.*);

`default_nettype wire

[bench/sound_energy_beat_detector_top_tb.sv]
// Testbench for the sound energy beat detector: self-checking regression with a built-in predictor.
`timescale 1ns / 1ps

module sound_energy_beat_detector_top_tb
    import sebd_pkg::*;
();

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 12;
    // Let a non-closing sample finish, with margin, before a register write.
    localparam int SETTLE_CYCLES  = 16;
    // Room for a closing sample with a history of up to 64 entries.
    localparam int TAIL_CYCLES    = 400;
    // Clearing pass plus the slowest set end plus receiver stalls, taken several times over.
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic                beat_found;
        logic [ENERGY_W-1:0] mean_energy;
        logic [ENERGY_W-1:0] set_energy;
    } set_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                        s_valid;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_beat_found;
    logic [ENERGY_W-1:0]         m_mean_energy;
    logic [ENERGY_W-1:0]         m_set_energy;
    logic                        cfg_wr_en;
    logic [CFG_ADDR_W-1:0]       cfg_addr;
    logic [CFG_DATA_W-1:0]       cfg_wdata;

    // Predictor copy of the configuration
    logic [SPS_W-1:0]    cfg_sps;
    logic [HSETS_W-1:0]  cfg_hsets;
    logic [BLF_W-1:0]    cfg_blf;
    logic [VF_W-1:0]     cfg_vf;

    // Predictor copy of the state
    logic [ENERGY_W-1:0] acc_energy;
    logic [SPS_W-1:0]    acc_count;
    logic [ENERGY_W-1:0] past_energy [HISTORY_DEPTH];

    set_result_t expected_sets [$];
    set_result_t want_set;

    int   error_count  = 0;
    int   stall_cycles = 0;
    bit   no_idle      = 1'b0;
    int   loud_shift   = 0;

    sound_energy_beat_detector_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_beat_found  (m_beat_found),
        .m_mean_energy (m_mean_energy),
        .m_set_energy  (m_set_energy),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: fold one accepted sample into the energy sum; on a set
    // end, form mean, variance and threshold, queue the expected result
    // and shift the history.
    // ------------------------------------------------------------------
    task automatic predict_sample(input logic signed [SAMPLE_W-1:0] smp);
        int                sq;
        longint            sum_next;
        int                n;
        longint unsigned   total;
        longint unsigned   mean;
        longint unsigned   vsum;
        longint            dev;
        logic [127:0]      prod;
        longint unsigned   var_term;
        longint            ratio;
        longint            rhs;
        longint            lhs;
        set_result_t       res;

        sq = int'(smp) * int'(smp);
        sum_next = longint'(acc_energy) + longint'(sq >> 15);
        // Saturate the accumulator at full scale
        acc_energy = (sum_next > longint'(ENERGY_MAX)) ? ENERGY_MAX : sum_next[ENERGY_W-1:0];
        acc_count = acc_count + SPS_W'(1);
        if (acc_count != cfg_sps) return;

        // A zero length counts as one entry; lengths past the store clamp to it
        n = int'(cfg_hsets);
        if (n == 0) n = 1;
        if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;

        total = 0;
        for (int i = 0; i < n; i++) total += past_energy[i];
        mean = total / n;
        vsum = 0;
        for (int i = 0; i < n; i++) begin
            dev = longint'(past_energy[i]) - longint'(mean);
            vsum += dev * dev;
        end
        vsum = vsum / n;

        // Variance weight; a product past 64 bits pins the term at 2^32
        prod = {64'd0, vsum} * {96'd0, cfg_vf};
        if (prod[127:64] != 0) var_term = 64'd1 << 32;
        else var_term = prod[63:36];
        ratio = longint'(cfg_blf) - longint'(var_term);
        rhs = ratio * longint'(mean);
        lhs = longint'(acc_energy) * 4096;

        res.beat_found  = (lhs > rhs);
        res.mean_energy = mean[ENERGY_W-1:0];
        res.set_energy  = acc_energy;
        expected_sets.push_back(res);

        for (int i = n - 1; i > 0; i--) past_energy[i] = past_energy[i-1];
        past_energy[0] = acc_energy;
        acc_energy = '0;
        acc_count  = '0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one sample; hold valid and payload until the transfer.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(smp);
    endtask

    // Drop valid, wait for every queued result, then let in-flight samples settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_sets.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Raise the write strobe for one register; the caller lowers it.
    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all four registers; junk above the width of each narrower register must be dropped.
    task automatic set_config(input int sps, input int hsets, input int blf,
                              input logic [VF_W-1:0] vf);
        put_reg(REG_SAMPLES_PER_SET,   ($urandom() << SPS_W)   | sps[SPS_W-1:0]);
        put_reg(REG_HISTORY_SETS,      ($urandom() << HSETS_W) | hsets[HSETS_W-1:0]);
        put_reg(REG_BEAT_LEVEL_FACTOR, ($urandom() << BLF_W)   | blf[BLF_W-1:0]);
        put_reg(REG_VARIANCE_FACTOR,   vf);
        cfg_wr_en <= 1'b0;
        cfg_sps   = sps[SPS_W-1:0];
        cfg_hsets = hsets[HSETS_W-1:0];
        cfg_blf   = blf[BLF_W-1:0];
        cfg_vf    = vf;
    endtask

    // Random sample with a loudness that drifts, so set energies rise and fall.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] raw;
        if ($urandom_range(0, 7) == 0) loud_shift = $urandom_range(0, 12);
        raw = SAMPLE_W'($urandom());
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return raw >>> loud_shift;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run two full sets and part of a third on the register values that reset leaves.
    task automatic test_reset_defaults();
        repeat (130) send_sample(random_sample());
    endtask

    // Extremes of the sample field and of every register.
    task automatic test_field_extremes();
        logic signed [SAMPLE_W-1:0] one_hist [8] =
            '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8000, 16'shc000, 0};
        logic signed [SAMPLE_W-1:0] deep_hist [10] =
            '{16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 0, 0,
              16'sh7fff, 16'sh7fff, 16'sh8000, 0};

        drain_results();
        // History length zero acts as one; highest base ratio
        set_config(1, 0, 16'hffff, 32'd0);
        foreach (one_hist[i]) send_sample(one_hist[i]);
        drain_results();
        // History length above the store; zero base ratio, largest variance weight
        set_config(2, 127, 0, 32'hffff_ffff);
        foreach (deep_hist[i]) send_sample(deep_hist[i]);
        drain_results();
        // History length exactly the store depth
        set_config(1, HISTORY_DEPTH, 4096, 32'h0001_0000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(0);
        send_sample(16'sh4000);
    endtask

    // Set length zero wraps to 256 samples; an all full-scale set saturates the sum,
    // and the next set sees a variance large enough to pin the weighted term.
    task automatic test_set_wrap_and_saturation();
        drain_results();
        set_config(0, 2, $urandom_range(0, 16'hffff), 32'hffff_ffff);
        no_idle = 1'b1;
        repeat (256) send_sample(16'sh8000);
        no_idle = 1'b0;
        loud_shift = 0;
        repeat (256) send_sample(SAMPLE_W'($urandom()));
        drain_results();
        // Longest regular set
        set_config(255, HISTORY_DEPTH, BLF_RESET, 32'd0);
        repeat (255) send_sample(random_sample());
    endtask

    // Phases of random samples, each on a fresh random configuration.
    task automatic test_random_phases();
        int sps;
        int hsets;
        int blf;
        logic [VF_W-1:0] vf;

        for (int phase = 0; phase < 10; phase++) begin
            drain_results();
            case ($urandom_range(0, 9))
                0, 1, 2: sps = 1;
                9:       sps = $urandom_range(9, 24);
                default: sps = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 5))
                0:       hsets = 0;
                1:       hsets = 1;
                2:       hsets = $urandom_range(2, 63);
                3:       hsets = HISTORY_DEPTH;
                4:       hsets = $urandom_range(HISTORY_DEPTH + 1, 127);
                default: hsets = $urandom_range(2, 16);
            endcase
            case ($urandom_range(0, 5))
                0:       blf = 0;
                1:       blf = 16'hffff;
                default: blf = $urandom_range(2048, 12288);
            endcase
            case ($urandom_range(0, 3))
                0:       vf = 32'd0;
                1:       vf = 32'hffff_ffff;
                2:       vf = $urandom_range(0, 1 << 20);
                default: vf = $urandom();
            endcase
            set_config(sps, hsets, blf, vf);
            // One phase runs without any idling on either side
            no_idle = (phase == 3);
            for (int k = 0; k < 50; k++) begin
                // Hold the sender once until the result queue empties
                if (phase == 5 && k == 25) drain_results();
                send_sample(random_sample());
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sets.size() == 0) begin
                $display("%0t ns: unexpected result, beat %0d mean %0d energy %0d",
                         $time, m_beat_found, m_mean_energy, m_set_energy);
                error_count++;
            end else begin
                want_set = expected_sets.pop_front();
                check_field("beat_found",  64'(want_set.beat_found),  64'(m_beat_found));
                check_field("mean_energy", 64'(want_set.mean_energy), 64'(m_mean_energy));
                check_field("set_energy",  64'(want_set.set_energy),  64'(m_set_energy));
            end
        end
    end

    // Watchdog: abort when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_SAMPLES_PER_SET;
        cfg_wdata = '0;

        cfg_sps    = SPS_RESET;
        cfg_hsets  = HSETS_RESET;
        cfg_blf    = BLF_RESET;
        cfg_vf     = VF_RESET;
        acc_energy = '0;
        acc_count  = '0;
        foreach (past_energy[i]) past_energy[i] = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_field_extremes();
        test_set_wrap_and_saturation();
        test_random_phases();

        // Drain, then watch a while longer for stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_sets.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/sebd_pkg.sv
rtl/sebd_ram.sv
rtl/sound_energy_beat_detector_top.sv
rtl/sebd_checker.sv
bench/sound_energy_beat_detector_top_tb.sv
